FILE: rtl/core/bced_pkg.sv
// Package of types and constants shared by the button click event detector.
`default_nettype none

package bced_pkg;

   // Default number of consecutive differing ticks before the level changes.
   localparam int unsigned DEBOUNCE_LEN_DEF = 3;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned TIMER_W     = 16;
   localparam int unsigned CLICK_W     = 8;

   localparam logic [CLICK_W-1:0] CLICK_MAX = '1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ACTIVE_LEVEL  = 2'd0,
      CSR_REPEAT_WINDOW = 2'd1,
      CSR_LONG_TIME     = 2'd2
   } csr_index_type;

   // One result word as it leaves the block.
   typedef struct packed {
      logic               pressed;
      logic               press_down;
      logic               press_up;
      logic               sequence_done;
      logic               single_click;
      logic               double_click;
      logic               multi_click;
      logic               long_hold;
      logic [CLICK_W-1:0] multi_click_count;
   } rsp_word_type;

endpackage

`default_nettype wire

FILE: rtl/core/button_click_event_detector.sv
// Button debounce, press edges, long hold and click-sequence classification.
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_stall   req_pin_level
//   rsp       out        rsp_valid/rsp_stall   pressed, press_down, ... multi_click_count
//   csr       in         csr_valid/csr_ready   csr_index, csr_wdata
//
// Each word is processed in the cycle it is accepted; its result goes to the result
// register, or to the skid register if that is held, so one word per cycle is sustained
// unless rsp stalls; the tick state is a single register stage updated in one pass.
// The two-entry output stage (result register plus skid register) lets req take one
// more word after rsp stalls; req_stall rises only when both are full. Synchronous reset
// sets all state but the result words; the configuration port is always ready.
`default_nettype none

module button_click_event_detector #(
   parameter int unsigned DEBOUNCE_LEN = bced_pkg::DEBOUNCE_LEN_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic                                req_pin_level,

   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic                                rsp_pressed,
   output      logic                                rsp_press_down,
   output      logic                                rsp_press_up,
   output      logic                                rsp_sequence_done,
   output      logic                                rsp_single_click,
   output      logic                                rsp_double_click,
   output      logic                                rsp_multi_click,
   output      logic                                rsp_long_hold,
   output      logic [bced_pkg::CLICK_W-1:0]        rsp_multi_click_count,

   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire logic [bced_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [bced_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import bced_pkg::*;

   localparam int unsigned DB_W = $clog2(DEBOUNCE_LEN + 1);
   localparam logic [DB_W-1:0] DB_LIMIT = DB_W'(DEBOUNCE_LEN);

   // Configuration registers.
   logic               active_level_ff, active_level_in;
   logic [TIMER_W-1:0] repeat_window_ff, repeat_window_in;
   logic [TIMER_W-1:0] long_time_ff, long_time_in;

   // Tick state.
   logic               debounced_ff, debounced_in;
   logic [DB_W-1:0]    db_count_ff, db_count_in;
   logic               held_ff, held_in;
   logic [TIMER_W-1:0] release_count_ff, release_count_in;
   logic [CLICK_W-1:0] click_count_ff, click_count_in;
   logic [TIMER_W-1:0] hold_count_ff, hold_count_in;
   logic [CLICK_W-1:0] last_multi_ff, last_multi_in;

   // Output stage.
   logic               out_valid_ff, out_valid_in;
   rsp_word_type       out_word_ff, out_word_in;
   logic               skid_valid_ff, skid_valid_in;
   rsp_word_type       skid_word_ff, skid_word_in;

   logic               req_take;
   logic               rsp_take;
   logic               csr_write;
   logic [DB_W-1:0]    db_count_inc;
   logic               level_now;
   logic               active;
   logic [TIMER_W-1:0] hold_count_inc;
   rsp_word_type       result;

   assign req_take  = req_valid & ~req_stall;
   assign rsp_take  = out_valid_ff & ~rsp_stall;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;
   assign req_stall = skid_valid_ff;

   assign db_count_inc   = db_count_ff + DB_W'(1);
   assign hold_count_inc = hold_count_ff + TIMER_W'(1);

   always_comb begin
      active_level_in  = active_level_ff;
      repeat_window_in = repeat_window_ff;
      long_time_in     = long_time_ff;
      debounced_in     = debounced_ff;
      db_count_in      = db_count_ff;
      held_in          = held_ff;
      release_count_in = release_count_ff;
      click_count_in   = click_count_ff;
      hold_count_in    = hold_count_ff;
      last_multi_in    = last_multi_ff;
      level_now        = debounced_ff;
      active           = 1'b0;
      result           = '0;

      if (req_take) begin
         // The stored level flips only after enough consecutive differing ticks.
         if (req_pin_level != debounced_ff) begin
            if (db_count_inc >= DB_LIMIT) begin
               level_now   = req_pin_level;
               db_count_in = '0;
            end else begin
               db_count_in = db_count_inc;
            end
         end else begin
            db_count_in = '0;
         end
         debounced_in = level_now;

         active         = (level_now == active_level_ff);
         held_in        = active;
         result.pressed = active;

         if (!active) begin
            result.press_up = held_ff;
            if (release_count_ff < repeat_window_ff) begin
               release_count_in = release_count_ff + TIMER_W'(1);
            end else if (click_count_ff != '0) begin
               result.sequence_done = 1'b1;
               if (click_count_ff == CLICK_W'(1)) begin
                  result.single_click = 1'b1;
               end else if (click_count_ff == CLICK_W'(2)) begin
                  result.double_click = 1'b1;
               end else begin
                  result.multi_click = 1'b1;
                  last_multi_in      = click_count_ff;
               end
               click_count_in = '0;
            end
         end else if (!held_ff) begin
            result.press_down = 1'b1;
            hold_count_in     = '0;
            release_count_in  = '0;
            if (click_count_ff != CLICK_MAX) begin
               click_count_in = click_count_ff + CLICK_W'(1);
            end
         end else begin
            // A zero hold period disables the pulse; the counter simply wraps.
            if ((long_time_ff != '0) && (hold_count_inc >= long_time_ff)) begin
               result.long_hold = 1'b1;
               hold_count_in    = '0;
            end else begin
               hold_count_in = hold_count_inc;
            end
         end
         result.multi_click_count = last_multi_in;
      end

      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_ACTIVE_LEVEL: begin
               active_level_in = csr_wdata[0];
               debounced_in    = ~csr_wdata[0];
               db_count_in     = '0;
            end
            CSR_REPEAT_WINDOW: repeat_window_in = csr_wdata[TIMER_W-1:0];
            CSR_LONG_TIME:     long_time_in     = csr_wdata[TIMER_W-1:0];
            default: begin
               // Writes beyond the register list are dropped.
            end
         endcase
      end
   end

   // Output register with a skid entry behind it.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_word_in   = out_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;

      if (rsp_take) begin
         out_valid_in = 1'b0;
      end
      if (rsp_take && skid_valid_ff) begin
         out_valid_in  = 1'b1;
         out_word_in   = skid_word_ff;
         skid_valid_in = 1'b0;
      end
      if (req_take) begin
         if (!out_valid_ff || rsp_take) begin
            out_valid_in = 1'b1;
            out_word_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_word_in  = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_level_ff  <= 1'b0;
         repeat_window_ff <= '0;
         long_time_ff     <= '0;
         debounced_ff     <= 1'b1;
         db_count_ff      <= '0;
         held_ff          <= 1'b0;
         release_count_ff <= '0;
         click_count_ff   <= '0;
         hold_count_ff    <= '0;
         last_multi_ff    <= '0;
         out_valid_ff     <= 1'b0;
         skid_valid_ff    <= 1'b0;
      end else begin
         active_level_ff  <= active_level_in;
         repeat_window_ff <= repeat_window_in;
         long_time_ff     <= long_time_in;
         debounced_ff     <= debounced_in;
         db_count_ff      <= db_count_in;
         held_ff          <= held_in;
         release_count_ff <= release_count_in;
         click_count_ff   <= click_count_in;
         hold_count_ff    <= hold_count_in;
         last_multi_ff    <= last_multi_in;
         out_valid_ff     <= out_valid_in;
         skid_valid_ff    <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_pressed           = out_word_ff.pressed;
   assign rsp_press_down        = out_word_ff.press_down;
   assign rsp_press_up          = out_word_ff.press_up;
   assign rsp_sequence_done     = out_word_ff.sequence_done;
   assign rsp_single_click      = out_word_ff.single_click;
   assign rsp_double_click      = out_word_ff.double_click;
   assign rsp_multi_click       = out_word_ff.multi_click;
   assign rsp_long_hold         = out_word_ff.long_hold;
   assign rsp_multi_click_count = out_word_ff.multi_click_count;

endmodule

`default_nettype wire

FILE: bench/button_click_event_detector_tb.sv
// Self-checking testbench for the button click event detector: debounce, edges, holds, clicks.
`timescale 1ns / 100ps

module button_click_event_detector_tb;
   import bced_pkg::*;

   localparam int unsigned DB_LEN = DEBOUNCE_LEN_DEF;
   localparam int unsigned WATCHDOG_LIMIT = 1000;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 2'd3;

   typedef enum logic [1:0] {
      PH_RELEASED    = 2'd0,
      PH_HELD        = 2'd2,
      PH_PRESS_START = 2'd3
   } tick_phase_type;

   logic                   clock         = 1'b0;
   logic                   reset         = 1'b1;
   logic                   req_valid     = 1'b0;
   logic                   req_pin_level = 1'b0;
   logic                   rsp_stall     = 1'b0;
   logic                   csr_valid     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index     = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata     = '0;

   logic                   req_stall;
   logic                   rsp_valid;
   logic                   rsp_pressed;
   logic                   rsp_press_down;
   logic                   rsp_press_up;
   logic                   rsp_sequence_done;
   logic                   rsp_single_click;
   logic                   rsp_double_click;
   logic                   rsp_multi_click;
   logic                   rsp_long_hold;
   logic [CLICK_W-1:0]     rsp_multi_click_count;
   logic                   csr_ready;

   // Pin samples waiting to be sent and result words still owed by the block.
   logic                   pin_queue[$];
   rsp_word_type           expected_words[$];
   int unsigned            queued_ticks = 0;

   logic                   req_fired  = 1'b0;
   logic                   csr_taken  = 1'b0;
   logic                   idle_on    = 1'b1;
   int unsigned            gap_left   = 0;
   int unsigned            stall_left = 0;
   int unsigned            idle_cycles = 0;
   int unsigned            mismatches = 0;

   // Predicted configuration and tick state.
   logic                   cfg_active     = 1'b0;
   logic [TIMER_W-1:0]     cfg_window     = '0;
   logic [TIMER_W-1:0]     cfg_long       = '0;
   logic                   db_level       = 1'b1;
   logic [7:0]             db_count       = '0;
   logic                   was_held       = 1'b0;
   tick_phase_type         last_phase     = PH_RELEASED;
   logic [TIMER_W-1:0]     released_ticks = '0;
   logic [CLICK_W-1:0]     clicks         = '0;
   logic [TIMER_W-1:0]     held_ticks     = '0;
   logic [CLICK_W-1:0]     multi_seen     = '0;

   button_click_event_detector #(
      .DEBOUNCE_LEN(DB_LEN)
   ) uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_pin_level        (req_pin_level),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_pressed          (rsp_pressed),
      .rsp_press_down       (rsp_press_down),
      .rsp_press_up         (rsp_press_up),
      .rsp_sequence_done    (rsp_sequence_done),
      .rsp_single_click     (rsp_single_click),
      .rsp_double_click     (rsp_double_click),
      .rsp_multi_click      (rsp_multi_click),
      .rsp_long_hold        (rsp_long_hold),
      .rsp_multi_click_count(rsp_multi_click_count),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic rsp_word_type predict_tick(input logic pin);
      rsp_word_type   w;
      logic           active;
      tick_phase_type ph;
      w = '0;
      if (pin != db_level) begin
         db_count = db_count + 8'd1;
         if (db_count >= DB_LEN) begin
            db_level = pin;
            db_count = '0;
         end
      end else begin
         db_count = '0;
      end
      active = (db_level == cfg_active);
      if (!active) begin
         ph = PH_RELEASED;
      end else if (!was_held) begin
         ph = PH_PRESS_START;
      end else begin
         ph = PH_HELD;
      end
      was_held = active;
      case (ph)
         PH_RELEASED: begin
            w.press_up = (last_phase != PH_RELEASED);
            if (released_ticks < cfg_window) begin
               released_ticks = released_ticks + 1'b1;
            end else if (clicks != 0) begin
               w.sequence_done = 1'b1;
               if (clicks == 1) begin
                  w.single_click = 1'b1;
               end else if (clicks == 2) begin
                  w.double_click = 1'b1;
               end else begin
                  multi_seen    = clicks;
                  w.multi_click = 1'b1;
               end
               clicks = '0;
            end
         end
         PH_PRESS_START: begin
            w.press_down   = 1'b1;
            held_ticks     = '0;
            released_ticks = '0;
            if (clicks != CLICK_MAX) clicks = clicks + 1'b1;
         end
         default: begin
            held_ticks = held_ticks + 1'b1;
            if (cfg_long != 0 && held_ticks >= cfg_long) begin
               w.long_hold = 1'b1;
               held_ticks  = '0;
            end
         end
      endcase
      last_phase          = ph;
      w.pressed           = active;
      w.multi_click_count = multi_seen;
      return w;
   endfunction

   task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] seen);
      if (want !== seen) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
         mismatches++;
      end
   endtask

   // Sender: a new word is put up only once the previous one has gone.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (gap_left != 0) begin
            req_valid <= 1'b0;
            gap_left  <= gap_left - 1;
         end else if (idle_on && pin_queue.size() != 0 && $urandom_range(0, 7) == 0) begin
            req_valid <= 1'b0;
            gap_left  <= $urandom_range(0, 6);
         end else if (pin_queue.size() != 0) begin
            req_valid     <= 1'b1;
            req_pin_level <= pin_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset || !idle_on) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 6);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : monitor
      rsp_word_type seen;
      rsp_word_type want;
      req_fired <= req_valid && !req_stall && !reset;
      csr_taken <= csr_valid && csr_ready;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = {rsp_pressed, rsp_press_down, rsp_press_up, rsp_sequence_done,
                 rsp_single_click, rsp_double_click, rsp_multi_click, rsp_long_hold,
                 rsp_multi_click_count};
         if (expected_words.size() == 0) begin
            $display("%0t ns: result word with none expected, expected none, actual %h",
                     $time, seen);
            mismatches++;
         end else begin
            want = expected_words.pop_front();
            check_field("pressed", 8'(want.pressed), 8'(seen.pressed));
            check_field("press_down", 8'(want.press_down), 8'(seen.press_down));
            check_field("press_up", 8'(want.press_up), 8'(seen.press_up));
            check_field("sequence_done", 8'(want.sequence_done), 8'(seen.sequence_done));
            check_field("single_click", 8'(want.single_click), 8'(seen.single_click));
            check_field("double_click", 8'(want.double_click), 8'(seen.double_click));
            check_field("multi_click", 8'(want.multi_click), 8'(seen.multi_click));
            check_field("long_hold", 8'(want.long_hold), 8'(seen.long_hold));
            check_field("multi_click_count", want.multi_click_count, seen.multi_click_count);
         end
      end
      if (!reset && req_valid && !req_stall) begin
         expected_words.push_back(predict_tick(req_pin_level));
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic queue_ticks(input logic level, input int unsigned count);
      repeat (count) pin_queue.push_back(level);
      queued_ticks += count;
   endtask

   task automatic push_click(input int unsigned press_len, input int unsigned release_len);
      queue_ticks(cfg_active, press_len);
      queue_ticks(~cfg_active, release_len);
   endtask

   // Returns at a falling edge once every word has been sent and answered.
   task automatic wait_drained;
      @(negedge clock);
      while (pin_queue.size() != 0 || req_valid || expected_words.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Called at a falling edge; leaves csr_valid high so that writes can follow back to back.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(negedge clock); while (!csr_taken);
      case (idx)
         CSR_ACTIVE_LEVEL: begin
            cfg_active = data[0];
            db_level   = ~data[0];
            db_count   = '0;
         end
         CSR_REPEAT_WINDOW: cfg_window = data;
         CSR_LONG_TIME:     cfg_long   = data;
         default: ;
      endcase
   endtask

   task automatic configure(input logic act, input logic [TIMER_W-1:0] window,
                            input logic [TIMER_W-1:0] long_ticks);
      wait_drained();
      write_csr(CSR_ACTIVE_LEVEL, {{(CSR_DATA_W-1){1'b0}}, act});
      write_csr(CSR_REPEAT_WINDOW, window);
      write_csr(CSR_LONG_TIME, long_ticks);
      // An index past the register list must leave everything as it was.
      write_csr(CSR_SPARE_INDEX, CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   task automatic random_traffic(input int unsigned budget);
      int unsigned stop_at;
      int unsigned gap_max;
      int unsigned press_len;
      stop_at = queued_ticks + budget;
      gap_max = (cfg_window < 16) ? cfg_window + 6 : 14;
      while (queued_ticks < stop_at) begin
         case ($urandom_range(0, 9))
            7, 8: begin
               repeat ($urandom_range(1, 8)) queue_ticks(1'($urandom_range(0, 1)), 1);
            end
            9: queue_ticks(~cfg_active, gap_max + 4);
            default: begin
               if ($urandom_range(0, 3) == 0) begin
                  // A bounce too short to get through the debounce.
                  queue_ticks(cfg_active, $urandom_range(1, DB_LEN - 1));
                  queue_ticks(~cfg_active, 1);
               end
               press_len = ($urandom_range(0, 4) == 0) ? $urandom_range(3, 40)
                                                       : $urandom_range(3, 8);
               push_click(press_len, $urandom_range(3, gap_max));
            end
         endcase
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: low level means pressed, no repeat window, long hold off.
      queue_ticks(1'b1, 1);
      queue_ticks(1'b0, 2);
      queue_ticks(1'b1, 1);
      queue_ticks(1'b0, 4);
      queue_ticks(1'b1, 3);

      configure(1'b1, 16'd3, 16'd2);
      push_click(5, 3);
      push_click(3, 3);
      push_click(3, 3);
      queue_ticks(1'b0, 4);

      for (int p = 0; p < 6; p++) begin
         case (p)
            0:       configure(1'b1, 16'd0, 16'd1);
            1:       configure(1'b0, 16'hFFFF, 16'hFFFF);
            default: configure(1'($urandom_range(0, 1)), TIMER_W'($urandom_range(1, 12)),
                               ($urandom_range(0, 3) == 0) ? TIMER_W'(0)
                                                           : TIMER_W'($urandom_range(2, 24)));
         endcase
         random_traffic(140);
      end

      // Hold with long hold disabled so the counter runs on, then enable it while still held.
      configure(1'($urandom_range(0, 1)), 16'd4, 16'd0);
      queue_ticks(cfg_active, 40);
      wait_drained();
      write_csr(CSR_LONG_TIME, 16'd6);
      csr_valid <= 1'b0;
      push_click(14, 10);

      configure(1'($urandom_range(0, 1)), TIMER_W'($urandom_range(2, 10)),
                TIMER_W'($urandom_range(2, 16)));
      idle_on <= 1'b0;
      random_traffic(150);

      wait_drained();
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/bced_pkg.sv
rtl/core/button_click_event_detector.sv
bench/button_click_event_detector_tb.sv
